>>> rtl/bdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the button debounce and hold detector.
// ----------------------------------------------------------------------------
package bdh_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int NOW_W          = 32;
	localparam int MS_W           = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = 2'd2;

	localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET   = 16'd60;
	localparam logic [MS_W-1:0] HOLD_MS_RESET       = 16'd1200;
	localparam logic            PRESSED_LEVEL_RESET = 1'b1;

	typedef struct packed {
		logic [MS_W-1:0] debounce_ms;
		logic [MS_W-1:0] hold_ms;
		logic            pressed_level;
	} bdh_cfg_t;

	typedef struct packed {
		logic pin_level;
		logic take_press;
		logic take_release;
		logic take_hold;
		logic clear_all;
	} bdh_ctl_t;

	typedef struct packed {
		logic press_event;
		logic release_event;
		logic hold_event;
		logic is_pressed;
		logic is_holding;
		logic stable_level;
	} bdh_result_t;

endpackage

>>> rtl/button_debounce_hold_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_hold_detector
// Debounces a raw button level and reports press, release and hold events.
// ----------------------------------------------------------------------------
// Flow: an accepted sample beat is registered in the input register; its result
// beat is registered in the result register when the output is not stalled.
// Throughput: one sample beat per cycle unless out_stall holds; the state update
// is one short pass of compares and subtracts between input and result registers.
// Reset: async, active low; valid flags, core state and events clear, the accepted
// level goes low, registers return to 60 ms debounce, 1200 ms hold, pressed high.
// ----------------------------------------------------------------------------
module button_debounce_hold_detector #(
	parameter int TIME_WIDTH = bdh_pkg::TIME_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pin_level,
	input  logic [bdh_pkg::NOW_W-1:0]       now_ms,
	input  logic                            take_press,
	input  logic                            take_release,
	input  logic                            take_hold,
	input  logic                            clear_all,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            press_event,
	output logic                            release_event,
	output logic                            hold_event,
	output logic                            is_pressed,
	output logic                            is_holding,
	output logic                            stable_level,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bdh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bdh_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bdh_pkg::*;

	bdh_cfg_t              cfg;
	logic [TIME_WIDTH-1:0] now_w;
	bdh_ctl_t              ctl_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  valid_s1;
	bdh_result_t           result_comb;
	bdh_result_t           result_s2;
	logic                  valid_s2;
	logic                  accept_in;
	logic                  advance;

	generate
		if (TIME_WIDTH <= NOW_W) begin : g_now_trunc
			assign now_w = now_ms[TIME_WIDTH-1:0];
		end else begin : g_now_ext
			assign now_w = {{(TIME_WIDTH-NOW_W){1'b0}}, now_ms};
		end
	endgenerate

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			ctl_s1.pin_level    <= pin_level;
			ctl_s1.take_press   <= take_press;
			ctl_s1.take_release <= take_release;
			ctl_s1.take_hold    <= take_hold;
			ctl_s1.clear_all    <= clear_all;
			now_s1              <= now_w;
		end
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	bdh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdh_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.ctl    (ctl_s1),
		.now    (now_s1),
		.result (result_comb)
	);

	assign out_valid     = valid_s2;
	assign press_event   = result_s2.press_event;
	assign release_event = result_s2.release_event;
	assign hold_event    = result_s2.hold_event;
	assign is_pressed    = result_s2.is_pressed;
	assign is_holding    = result_s2.is_holding;
	assign stable_level  = result_s2.stable_level;

endmodule

>>> rtl/bdh_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdh_cfg
// Configuration register file: debounce time, hold time and pressed level.
// ----------------------------------------------------------------------------
module bdh_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bdh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bdh_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bdh_pkg::bdh_cfg_t               cfg
);
	import bdh_pkg::*;

	bdh_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_MS_RESET;
			cfg_q.hold_ms       <= HOLD_MS_RESET;
			cfg_q.pressed_level <= PRESSED_LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE_MS: begin
					cfg_q.debounce_ms <= cfg_data[MS_W-1:0];
				end
				REG_HOLD_MS: begin
					cfg_q.hold_ms <= cfg_data[MS_W-1:0];
				end
				REG_PRESSED_LEVEL: begin
					cfg_q.pressed_level <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/bdh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdh_core
// Debounce and hold state with the single-pass update for one sample beat.
// ----------------------------------------------------------------------------
module bdh_core #(
	parameter int TIME_WIDTH = bdh_pkg::TIME_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  bdh_pkg::bdh_cfg_t       cfg,
	input  bdh_pkg::bdh_ctl_t       ctl,
	input  logic [TIME_WIDTH-1:0]   now,
	output bdh_pkg::bdh_result_t    result
);
	import bdh_pkg::*;

	logic                  accepted_level_q, accepted_level_d;
	logic [TIME_WIDTH-1:0] debounce_start_q, debounce_start_d;
	logic                  debounce_armed_q, debounce_armed_d;
	logic [TIME_WIDTH-1:0] press_start_q, press_start_d;
	logic                  press_timing_q, press_timing_d;
	logic                  hold_reached_q, hold_reached_d;
	logic                  hold_pending_q, hold_pending_d;
	logic                  press_pending_q, press_pending_d;
	logic                  release_pending_q, release_pending_d;

	logic [TIME_WIDTH-1:0] press_elapsed;
	logic [TIME_WIDTH-1:0] debounce_elapsed;

	always_comb begin
		accepted_level_d  = accepted_level_q;
		debounce_start_d  = debounce_start_q;
		debounce_armed_d  = debounce_armed_q;
		press_start_d     = press_start_q;
		press_timing_d    = press_timing_q;
		hold_reached_d    = hold_reached_q;
		hold_pending_d    = hold_pending_q;
		press_pending_d   = press_pending_q;
		release_pending_d = release_pending_q;

		if (ctl.clear_all) begin
			debounce_start_d  = '0;
			debounce_armed_d  = 1'b0;
			press_start_d     = '0;
			press_timing_d    = 1'b0;
			hold_reached_d    = 1'b0;
			hold_pending_d    = 1'b0;
			press_pending_d   = 1'b0;
			release_pending_d = 1'b0;
		end

		press_elapsed    = now - press_start_d;
		debounce_elapsed = now - debounce_start_d;

		if (ctl.pin_level == accepted_level_d) begin
			debounce_armed_d = 1'b0;
			if (!hold_reached_d && press_timing_d &&
			    press_elapsed > TIME_WIDTH'(cfg.hold_ms)) begin
				hold_reached_d = 1'b1;
				hold_pending_d = 1'b1;
				press_timing_d = 1'b0;
			end
		end else if (!debounce_armed_d) begin
			debounce_armed_d = 1'b1;
			debounce_start_d = now;
		end else if (debounce_elapsed >= TIME_WIDTH'(cfg.debounce_ms)) begin
			debounce_armed_d = 1'b0;
			accepted_level_d = ctl.pin_level;
			hold_pending_d   = 1'b0;
			hold_reached_d   = 1'b0;
			if (ctl.pin_level == cfg.pressed_level) begin
				press_pending_d = 1'b1;
				press_start_d   = now;
				press_timing_d  = 1'b1;
			end else begin
				release_pending_d = 1'b1;
				press_timing_d    = 1'b0;
			end
		end

		result.press_event   = press_pending_d;
		result.release_event = release_pending_d;
		result.hold_event    = hold_pending_d;
		result.is_pressed    = (accepted_level_d == cfg.pressed_level);
		result.is_holding    = hold_reached_d;
		result.stable_level  = accepted_level_d;

		if (ctl.take_press) begin
			press_pending_d = 1'b0;
		end
		if (ctl.take_release) begin
			release_pending_d = 1'b0;
		end
		if (ctl.take_hold && hold_pending_d) begin
			hold_pending_d = 1'b0;
			press_timing_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_level_q  <= 1'b0;
			debounce_start_q  <= '0;
			debounce_armed_q  <= 1'b0;
			press_start_q     <= '0;
			press_timing_q    <= 1'b0;
			hold_reached_q    <= 1'b0;
			hold_pending_q    <= 1'b0;
			press_pending_q   <= 1'b0;
			release_pending_q <= 1'b0;
		end else if (en) begin
			accepted_level_q  <= accepted_level_d;
			debounce_start_q  <= debounce_start_d;
			debounce_armed_q  <= debounce_armed_d;
			press_start_q     <= press_start_d;
			press_timing_q    <= press_timing_d;
			hold_reached_q    <= hold_reached_d;
			hold_pending_q    <= hold_pending_d;
			press_pending_q   <= press_pending_d;
			release_pending_q <= release_pending_d;
		end
	end

	// A pending hold event always belongs to a press that reached its hold time.
	a_hold_pending_reached: assert property (@(posedge clk) disable iff (!arst_n)
		hold_pending_q |-> hold_reached_q)
		else $error("hold event pending without hold reached");

	// Press timing stops once the hold threshold has been passed.
	a_reached_not_timing: assert property (@(posedge clk) disable iff (!arst_n)
		hold_reached_q |-> !press_timing_q)
		else $error("press timing still running after hold reached");

	// A clearing beat leaves no event behind, since no edge can complete on it.
	a_clear_no_events: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctl.clear_all |=> !press_pending_q && !release_pending_q && !hold_pending_q)
		else $error("event pending after clear_all beat");

endmodule
